### rtl/present_block_cipher_unit_macros.svh
// Assertion macros for the PRESENT cipher unit checker.
// Depends on a clk and rst_n in the scope where a macro is used.
`ifndef PRESENT_BLOCK_CIPHER_UNIT_MACROS_SVH
`define PRESENT_BLOCK_CIPHER_UNIT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define PBCU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every rising edge, reset included.
`define PBCU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### rtl/present_pkg.sv
// Shared types, constants and round functions of the PRESENT cipher unit.
// No dependencies; every module in the project imports this package.
`timescale 1ns / 1ps

package present_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int BLOCK_W     = 64;
    localparam int KEY_W       = 128;
    localparam int RC_W        = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CNT_W       = $clog2(ROUND_COUNT);
    localparam int LATENCY     = ROUND_COUNT + 1;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [KEY_W-1:0]   key_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_HI   = 2'd0,
        CFG_KEY_LO   = 2'd1,
        CFG_KEY_MODE = 2'd2
    } cfg_index_t;

    typedef enum logic {
        KEY_80  = 1'b0,
        KEY_128 = 1'b1
    } key_mode_t;

    typedef enum logic {
        CMD_ENC = 1'b0,
        CMD_DEC = 1'b1
    } cmd_t;

    typedef struct packed {
        logic   valid;
        cmd_t   cmd;
        block_t blk;
    } stage_t;

    localparam logic [3:0] SBOX_FWD [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };
    localparam logic [3:0] SBOX_INV [16] = '{
        4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
        4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
    };

    // Nibble-wise S-box layer, forward or inverse.
    function automatic block_t sub_layer(block_t x, logic inv);
        block_t r;
        r = '0;
        for (int n = 0; n < BLOCK_W / 4; n++)
        begin
            r[4*n +: 4] = inv ? SBOX_INV[x[4*n +: 4]] : SBOX_FWD[x[4*n +: 4]];
        end
        return r;
    endfunction

    // Bit i moves to 16*(i mod 4) + i/4.
    function automatic block_t perm_fwd(block_t x);
        block_t     r;
        logic [5:0] src;
        logic [5:0] dst;
        r = '0;
        for (int i = 0; i < BLOCK_W; i++)
        begin
            src    = 6'(i);
            dst    = {src[1:0], src[5:2]};
            r[dst] = x[src];
        end
        return r;
    endfunction

    function automatic block_t perm_inv(block_t x);
        block_t     r;
        logic [5:0] src;
        logic [5:0] dst;
        r = '0;
        for (int i = 0; i < BLOCK_W; i++)
        begin
            src    = 6'(i);
            dst    = {src[1:0], src[5:2]};
            r[src] = x[dst];
        end
        return r;
    endfunction

    // One key schedule step; the 80-bit state lives in bits 79..0.
    function automatic key_state_t key_update(key_state_t k, key_mode_t mode,
                                              logic [RC_W-1:0] rc);
        key_state_t  n;
        logic [79:0] k80;
        if (mode == KEY_128)
        begin
            n            = {k[66:0], k[127:67]};
            n[127:124]   = SBOX_FWD[n[127:124]];
            n[123:120]   = SBOX_FWD[n[123:120]];
            n[66:62]     = n[66:62] ^ rc;
        end
        else
        begin
            k80          = {k[18:0], k[79:19]};
            k80[79:76]   = SBOX_FWD[k80[79:76]];
            k80[19:15]   = k80[19:15] ^ rc;
            n            = {48'b0, k80};
        end
        return n;
    endfunction

    function automatic block_t round_key(key_state_t k, key_mode_t mode);
        return (mode == KEY_128) ? k[127:64] : k[79:16];
    endfunction

endpackage

### rtl/present_block_cipher_unit.sv
// Top level of the PRESENT cipher unit: config registers, key and round chains.
// Depends on present_pkg, present_key_cell and present_round_cell.
`timescale 1ns / 1ps

// PRESENT block cipher, 64-bit block, 80-bit or 128-bit key.
//
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data. Index 0
// is key_hi, 1 is key_lo, 2 is key_length_mode (bit 0); index 3 is dropped.
// cfg_ready is always high. Write config only while no word is in flight.
//
// Command channel: a word (cmd, block_in) is taken on a rising edge with
// start high and busy low. It passes the input register, the round cells
// and the output register; done then rises and block_out holds the result
// for that one cycle. The receiver cannot stall; done is a strobe and the
// word is gone after it.
//
// Throughput is one word per cycle while busy is low: 31 round cells form a
// pipeline and a final stage adds the last round key. Round keys come from a
// parallel chain of 31 key cells that each step the key schedule once per
// cycle. After reset and after every config write the key chain must settle;
// busy is high while a settle counter counts down. Reset clears the key
// registers to zero, drops every word in flight and raises busy.

module present_block_cipher_unit
    import present_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 cmd,
    input  logic [BLOCK_W-1:0]   block_in,
    output logic [BLOCK_W-1:0]   block_out,
    output logic                 done,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BLOCK_W-1:0]   cfg_data
);

    // Config registers
    block_t    key_hi_reg;
    block_t    key_lo_reg;
    key_mode_t key_mode_reg;
    logic      cfg_write;

    // Key settle counter; busy while the key chain catches up
    logic [CNT_W-1:0] settle_cnt_reg;
    logic [CNT_W-1:0] settle_cnt_next;

    // Key chain and round keys
    key_state_t key_state [ROUND_COUNT];
    block_t     rk        [ROUND_COUNT];

    // Data chain
    logic   in_valid_reg;
    cmd_t   in_cmd_reg;
    block_t in_blk_reg;
    stage_t stage [ROUND_COUNT];
    stage_t last_stage;

    // Output stage
    logic   done_reg;
    block_t out_blk_reg;
    block_t final_key;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Take config words; an unknown index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg   <= '0;
            key_lo_reg   <= '0;
            key_mode_reg <= KEY_80;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_KEY_HI:   key_hi_reg   <= cfg_data;
                CFG_KEY_LO:   key_lo_reg   <= cfg_data;
                CFG_KEY_MODE: key_mode_reg <= key_mode_t'(cfg_data[0]);
                default:      ;
            endcase
        end
    end

    // Restart the settle count on every config word, count down to zero.
    always_comb
    begin
        if (cfg_write)
            settle_cnt_next = CNT_W'(ROUND_COUNT - 1);
        else if (settle_cnt_reg != '0)
            settle_cnt_next = settle_cnt_reg - 1'b1;
        else
            settle_cnt_next = settle_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_cnt_reg <= CNT_W'(ROUND_COUNT - 1);
        else
            settle_cnt_reg <= settle_cnt_next;
    end

    assign busy = (settle_cnt_reg != '0);

    // Head of the key chain: the key as written, 80-bit keys in bits 79..0.
    assign key_state[0] = (key_mode_reg == KEY_128)
                        ? {key_hi_reg, key_lo_reg}
                        : {48'b0, key_hi_reg, key_lo_reg[63:48]};

    genvar r;
    generate
        for (r = 1; r < ROUND_COUNT; r++)
        begin : g_key
            present_key_cell u_key_cell (
                .clk        (clk),
                .prev_state (key_state[r-1]),
                .mode       (key_mode_reg),
                .rc         (RC_W'(r)),
                .state      (key_state[r])
            );
        end
        for (r = 0; r < ROUND_COUNT; r++)
        begin : g_rk
            assign rk[r] = round_key(key_state[r], key_mode_reg);
        end
    endgenerate

    // Capture the command word into the head of the data chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_cmd_reg <= cmd_t'(cmd);
        in_blk_reg <= block_in;
    end

    assign stage[0] = '{valid: in_valid_reg, cmd: in_cmd_reg, blk: in_blk_reg};

    // Round s uses key s going forward and key ROUND_COUNT-1-s going back.
    generate
        for (r = 0; r < ROUND_COUNT - 1; r++)
        begin : g_round
            present_round_cell u_round_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_stage  (stage[r]),
                .rk_enc    (rk[r]),
                .rk_dec    (rk[ROUND_COUNT-1-r]),
                .out_stage (stage[r+1])
            );
        end
    endgenerate

    assign last_stage = stage[ROUND_COUNT-1];
    assign final_key  = (last_stage.cmd == CMD_DEC) ? rk[0] : rk[ROUND_COUNT-1];

    // Final key add and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= last_stage.valid;
    end

    always_ff @(posedge clk)
    begin
        out_blk_reg <= last_stage.blk ^ final_key;
    end

    assign done      = done_reg;
    assign block_out = out_blk_reg;

endmodule

### rtl/present_key_cell.sv
// One cell of the key schedule chain: holds one key register state.
// Depends on present_pkg for the key update function.
`timescale 1ns / 1ps

module present_key_cell
    import present_pkg::*;
(
    input  logic            clk,
    input  key_state_t      prev_state,
    input  key_mode_t       mode,
    input  logic [RC_W-1:0] rc,
    output key_state_t      state
);

    key_state_t state_reg;

    // Advance from the neighbor every cycle; settles after a key change.
    always_ff @(posedge clk)
    begin
        state_reg <= key_update(prev_state, mode, rc);
    end

    assign state = state_reg;

endmodule

### rtl/present_round_cell.sv
// Round cell: key add, S-box, permutation; decrypt: inv perm, then inv S-box.
// Depends on present_pkg for the stage type and round functions.
`timescale 1ns / 1ps

module present_round_cell
    import present_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  stage_t in_stage,
    input  block_t rk_enc,
    input  block_t rk_dec,
    output stage_t out_stage
);

    logic   valid_reg;
    cmd_t   cmd_reg;
    block_t blk_reg;
    block_t blk_next;

    always_comb
    begin
        if (in_stage.cmd == CMD_DEC)
            blk_next = sub_layer(perm_inv(in_stage.blk ^ rk_dec), 1'b1);
        else
            blk_next = perm_fwd(sub_layer(in_stage.blk ^ rk_enc, 1'b0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_stage.valid;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= in_stage.cmd;
        blk_reg <= blk_next;
    end

    assign out_stage = '{valid: valid_reg, cmd: cmd_reg, blk: blk_reg};

endmodule

### rtl/present_block_cipher_unit_chk.sv
// Port-level checker for the PRESENT cipher unit, bound to the top level.
// Depends on present_pkg and present_block_cipher_unit_macros.svh.
`timescale 1ns / 1ps
`include "present_block_cipher_unit_macros.svh"

module present_block_cipher_unit_chk
    import present_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic                 cfg_valid,
    input logic                 cfg_ready
);

    // Every accepted word comes out of the chain with a done strobe.
    `PBCU_ASSERT(a_done_after_accept, (start && !busy) |-> ##LATENCY done, "word lost in chain")
    // No result strobe without an accepted word behind it.
    `PBCU_ASSERT(a_done_has_source, done |-> $past(start && !busy, LATENCY), "spurious done")
    // A config word holds off commands while the key chain settles.
    `PBCU_ASSERT(a_busy_after_cfg, (cfg_valid && cfg_ready) |=> busy, "busy missing after cfg")
    // Config channel never stalls.
    `PBCU_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "cfg_ready low")

endmodule

bind present_block_cipher_unit present_block_cipher_unit_chk u_chk (.*);

### dv/tb_present_block_cipher_unit.sv
// Self-checking testbench for present_block_cipher_unit: encrypt and decrypt
// words under 80-bit and 128-bit keys against an in-bench cipher predictor.
// Depends on present_pkg and the present_block_cipher_unit RTL.
`timescale 1ns / 1ps

module tb_present_block_cipher_unit;
    import present_pkg::*;

    // Run length and timeout knobs.
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_WORDS   = 170;
    localparam int RANDOM_PHASES = 8;

    // The config index that maps to no register; a write there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    // S-box tables packed one nibble per entry: nibble i holds the image of i.
    localparam logic [63:0] SBOX_FWD_NIBBLES = 64'h2174_8FE3_DA09_B65C;
    localparam logic [63:0] SBOX_INV_NIBBLES = 64'hA970_364B_D21C_8FE5;

    // One command word: operation plus the block to transform.
    typedef struct {
        cmd_t               op;
        logic [BLOCK_W-1:0] data;
    } block_word_t;

    // One expected result, kept with its source word for error reports.
    typedef struct {
        cmd_t               op;
        logic [BLOCK_W-1:0] source;
        logic [BLOCK_W-1:0] result;
    } cipher_result_t;

    // DUT connections; every input starts at a known value.
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    logic                 cmd       = 1'b0;
    logic [BLOCK_W-1:0]   block_in  = '0;
    logic [BLOCK_W-1:0]   block_out;
    logic                 done;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BLOCK_W-1:0]   cfg_data  = '0;

    // Predictor copy of the key registers and the round keys derived from them.
    logic [63:0]          key_hi_q  = '0;
    logic [63:0]          key_lo_q  = '0;
    key_mode_t            key_len_q = KEY_80;
    logic [63:0]          round_keys [ROUND_COUNT];

    // Words waiting for the driver, and results waiting for the monitor.
    block_word_t          pending_words [$];
    cipher_result_t       expected_blocks [$];

    // Driver burst state and run bookkeeping.
    block_word_t          next_word;
    int                   burst_left     = 0;
    int                   gap_left       = 0;
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;

    present_block_cipher_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .block_in  (block_in),
        .block_out (block_out),
        .done      (done),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Cipher predictor
    // ------------------------------------------------------------------

    // Push every nibble through the forward or inverse S-box.
    function automatic logic [63:0] substitute(logic [63:0] x, bit undo);
        logic [63:0] tab;
        logic [63:0] r;
        tab = undo ? SBOX_INV_NIBBLES : SBOX_FWD_NIBBLES;
        for (int n = 0; n < 16; n++)
        begin
            r[4*n +: 4] = tab[4*x[4*n +: 4] +: 4];
        end
        return r;
    endfunction

    // Bit i moves to 16*i mod 63, bit 63 stays put; undo pulls it back.
    function automatic logic [63:0] shuffle_bits(logic [63:0] x, bit undo);
        logic [63:0] r;
        int unsigned pos;
        r = '0;
        for (int unsigned i = 0; i < 64; i++)
        begin
            pos = (i == 63) ? 63 : (16 * i) % 63;
            if (undo)
                r[i] = x[pos];
            else
                r[pos] = x[i];
        end
        return r;
    endfunction

    // Rebuild all round keys from the current key registers. The schedule
    // rotates the key left by 61, runs the top nibble (two nibbles for a
    // 128-bit key) through the S-box and folds in the 5-bit round counter.
    function automatic void expand_key_schedule();
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] nhi;
        logic [63:0] nlo;
        logic [4:0]  rc;
        hi = key_hi_q;
        // An 80-bit key only uses key_lo bits 63..48.
        lo = (key_len_q == KEY_128) ? key_lo_q : {48'b0, key_lo_q[63:48]};
        round_keys[0] = hi;
        for (int r = 1; r < ROUND_COUNT; r++)
        begin
            rc = 5'(r);
            if (key_len_q == KEY_128)
            begin
                nhi = {hi[2:0], lo[63:3]};
                nlo = {lo[2:0], hi[63:3]};
                nhi[63:60] = SBOX_FWD_NIBBLES[4*nhi[63:60] +: 4];
                nhi[59:56] = SBOX_FWD_NIBBLES[4*nhi[59:56] +: 4];
                nhi[2:0]   = nhi[2:0] ^ rc[4:2];
                nlo[63:62] = nlo[63:62] ^ rc[1:0];
            end
            else
            begin
                nhi = {hi[2:0], lo[15:0], hi[63:19]};
                nlo = {48'b0, hi[18:3]};
                nhi[63:60] = SBOX_FWD_NIBBLES[4*nhi[63:60] +: 4];
                nhi[3:0]   = nhi[3:0] ^ rc[4:1];
                nlo[15]    = nlo[15] ^ rc[0];
            end
            hi            = nhi;
            lo            = nlo;
            round_keys[r] = hi;
        end
    endfunction

    // Full encrypt or decrypt of one block under the current round keys.
    function automatic logic [63:0] cipher_block(cmd_t op, logic [63:0] x);
        logic [63:0] b;
        b = x;
        if (op == CMD_ENC)
        begin
            for (int r = 0; r < ROUND_COUNT - 1; r++)
            begin
                b = shuffle_bits(substitute(b ^ round_keys[r], 1'b0), 1'b0);
            end
            b = b ^ round_keys[ROUND_COUNT - 1];
        end
        else
        begin
            for (int r = ROUND_COUNT - 1; r > 0; r--)
            begin
                b = substitute(shuffle_bits(b ^ round_keys[r], 1'b1), 1'b1);
            end
            b = b ^ round_keys[0];
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly uniform blocks, with a share of all-zero, all-one and walking bits.
    function automatic logic [63:0] random_block();
        logic [63:0] one_hot;
        one_hot = 64'h1 << $urandom_range(0, 63);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Write one register over the config channel, then mirror it in the
    // predictor. Call only while no word is in flight.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_KEY_HI:   key_hi_q  = value;
            CFG_KEY_LO:   key_lo_q  = value;
            CFG_KEY_MODE: key_len_q = key_mode_t'(value[0]);
            default:      ;
        endcase
        expand_key_schedule();
    endtask

    // Load a full key. Shuffle the write order, put junk in the upper bits
    // of the mode word and now and then poke the unmapped index.
    task automatic load_key(key_mode_t mode, logic [63:0] hi, logic [63:0] lo);
        logic [63:0] mode_word;
        mode_word    = {$urandom, $urandom};
        mode_word[0] = mode;
        if ($urandom_range(0, 1))
        begin
            write_register(CFG_KEY_HI, hi);
            write_register(CFG_KEY_LO, lo);
        end
        else
        begin
            write_register(CFG_KEY_LO, lo);
            write_register(CFG_KEY_HI, hi);
        end
        if ($urandom_range(0, 2) == 0)
            write_register(CFG_UNMAPPED, {$urandom, $urandom});
        write_register(CFG_KEY_MODE, mode_word);
    endtask

    // Queue random words. About a fifth come as round trips: a block and then
    // its predicted image, sent with the opposite operation.
    task automatic queue_random_words(int count);
        logic [63:0] x;
        cmd_t        op;
        cmd_t        back;
        @(negedge clk);
        for (int k = 0; k < count; k++)
        begin
            x  = random_block();
            op = cmd_t'($urandom_range(0, 1));
            pending_words.push_back('{op, x});
            if ($urandom_range(0, 4) == 0)
            begin
                back = (op == CMD_ENC) ? CMD_DEC : CMD_ENC;
                pending_words.push_back('{back, cipher_block(op, x)});
                k++;
            end
        end
    endtask

    // Wait until every word is taken and every result is back, then let the
    // pipeline go quiet. Sample at the falling edge to stay clear of updates.
    task automatic drain_pipeline();
        @(negedge clk);
        while (pending_words.size() != 0 || start || expected_blocks.size() != 0)
            @(negedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: issue words from pending_words in bursts with random gaps.
    // A word is taken at an edge with start high and busy low; hold it
    // until then. Record its expected result at the edge that takes it.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            cmd      <= 1'b0;
            block_in <= '0;
        end
        else
        begin
            if (start && !busy)
                expected_blocks.push_back('{cmd_t'(cmd), block_in,
                                            cipher_block(cmd_t'(cmd), block_in)});
            // Advance only when the current word is gone or none is offered.
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    next_word = pending_words.pop_front();
                    start    <= 1'b1;
                    cmd      <= next_word.op;
                    block_in <= next_word.data;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        // Pick the next burst; some run long, some end with no gap.
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: done marks a result for one cycle; compare it with the
    // oldest expectation. The receiver never stalls here.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_blocks.size() == 0)
            begin
                $error("block_out: no result expected, actual %h", block_out);
                mismatch_count++;
            end
            else if (block_out !== expected_blocks[0].result)
            begin
                $error("block_out: expected %h, actual %h (cmd %s, block_in %h)",
                       expected_blocks[0].result, block_out,
                       expected_blocks[0].op.name(), expected_blocks[0].source);
                mismatch_count++;
                void'(expected_blocks.pop_front());
            end
            else
                void'(expected_blocks.pop_front());
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** present_block_cipher_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        expand_key_schedule();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset key (all zero, 80-bit): field
        // extremes, alternating bits, single bits and a round trip, both ways.
        @(negedge clk);
        pending_words.push_back('{CMD_ENC, 64'h0});
        pending_words.push_back('{CMD_DEC, 64'h0});
        pending_words.push_back('{CMD_ENC, '1});
        pending_words.push_back('{CMD_DEC, '1});
        pending_words.push_back('{CMD_ENC, 64'h0000_0000_0000_0001});
        pending_words.push_back('{CMD_DEC, 64'h0000_0000_0000_0001});
        pending_words.push_back('{CMD_ENC, 64'h8000_0000_0000_0000});
        pending_words.push_back('{CMD_DEC, 64'h8000_0000_0000_0000});
        pending_words.push_back('{CMD_ENC, 64'h5555_5555_5555_5555});
        pending_words.push_back('{CMD_DEC, 64'hAAAA_AAAA_AAAA_AAAA});
        pending_words.push_back('{CMD_ENC, 64'h0123_4567_89AB_CDEF});
        pending_words.push_back('{CMD_DEC, cipher_block(CMD_ENC, 64'h0123_4567_89AB_CDEF)});
        drain_pipeline();

        // Key extremes in both lengths.
        load_key(KEY_80, '1, '1);
        queue_random_words(PHASE_WORDS);
        drain_pipeline();
        load_key(KEY_128, '0, '0);
        queue_random_words(PHASE_WORDS);
        drain_pipeline();
        load_key(KEY_128, '1, '1);
        queue_random_words(PHASE_WORDS);
        drain_pipeline();

        // 80-bit key with noise in the key_lo bits that must be ignored.
        load_key(KEY_80, {$urandom, $urandom}, {$urandom, $urandom});
        queue_random_words(PHASE_WORDS);
        drain_pipeline();

        // Random keys, random lengths, with a pattern key now and then.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if ($urandom_range(0, 3) == 0)
                load_key(key_mode_t'($urandom_range(0, 1)),
                         64'hA5A5_5A5A_F00F_0FF0, 64'h0F0F_F0F0_3C3C_C3C3);
            else
                load_key(key_mode_t'($urandom_range(0, 1)),
                         {$urandom, $urandom}, {$urandom, $urandom});
            queue_random_words(PHASE_WORDS);
            drain_pipeline();
        end

        if (mismatch_count == 0)
            $display("** present_block_cipher_unit: PASSED **");
        else
            $display("** present_block_cipher_unit: FAILED **");
        $finish;
    end

endmodule

### present_block_cipher_unit.f
+incdir+rtl
rtl/present_pkg.sv
rtl/present_key_cell.sv
rtl/present_round_cell.sv
rtl/present_block_cipher_unit.sv
rtl/present_block_cipher_unit_chk.sv
dv/tb_present_block_cipher_unit.sv
